// File: rtl/rc4_stream_cipher_macros.svh
// assertion helpers for the rc4 stream cipher checker
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// clocked check, off while reset is held
`define RC4_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rc4 stream cipher check failed");

// clocked check that also runs through reset
`define RC4_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("rc4 stream cipher reset check failed");

`endif

// File: rtl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int SBOX_DEPTH = 256;
    localparam int ADDR_W     = $clog2(SBOX_DEPTH);
    localparam int KEY_LEN_W  = 9;
    localparam int ACT_W      = 2;
    localparam int S_DATA_W   = 24;

    localparam logic [KEY_LEN_W-1:0] MAX_KEY_BYTES = 9'd256;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    // item kind carried on s_tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_KEY = 2'd0,
        ACT_SCHEDULE = 2'd1,
        ACT_DATA     = 2'd2
    } action_t;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_GEN_J      = 9'b000000010,
        ST_GEN_SWAP_I = 9'b000000100,
        ST_GEN_SWAP_J = 9'b000001000,
        ST_GEN_OUT    = 9'b000010000,
        ST_KS_READ    = 9'b000100000,
        ST_KS_J       = 9'b001000000,
        ST_KS_SWAP_K  = 9'b010000000,
        ST_KS_SWAP_J  = 9'b100000000
    } state_t;

    // access request to the permutation table
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } perm_req_t;

endpackage

`default_nettype wire

// File: rtl/rc4_stream_cipher.sv
// RC4 stream cipher, one byte per beat; encryption and decryption are the same
// operation. s_tuser picks the item kind: load one key byte, run the key
// schedule, or transform one data byte. Key bytes must be loaded for every
// index below key_length before a schedule is run. A key byte load leaves the
// block idle. A data byte passes ST_GEN_J, ST_GEN_SWAP_I and ST_GEN_SWAP_J to
// its result on m_*; s_tready returns in the same cycle as the result, so no new
// byte is taken before the last is out; a stalled m_tready holds the block in its
// last step. A key schedule resets the table on acceptance, then runs 256 steps
// of ST_KS_READ, ST_KS_J, ST_KS_SWAP_K and ST_KS_SWAP_J, as the single
// permutation memory serves one read and one write per cycle for the two swap
// writes and the dependent reads. key_length must be written over cfg_* only
// while idle; the block does not enforce it. Zero acts as one, over 256 as 256.
`default_nettype none

module rc4_stream_cipher (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // input beat
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [rc4_pkg::S_DATA_W-1:0] s_tdata,  // key_index, key_byte, data_byte
    input  wire logic [rc4_pkg::ACT_W-1:0]   s_tuser,   // action
    // result beat
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [rc4_pkg::BYTE_W-1:0]  m_tdata,   // out_byte
    // key length register
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data
);

    import rc4_pkg::*;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    i_reg, i_next;
    logic [ADDR_W-1:0]    j_reg, j_next;
    logic [ADDR_W-1:0]    k_reg, k_next;
    logic [ADDR_W-1:0]    kk_reg, kk_next;
    logic [BYTE_W-1:0]    si_reg, si_next;
    logic [BYTE_W-1:0]    sx_reg, sx_next;
    logic [ADDR_W-1:0]    t_reg, t_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [BYTE_W-1:0]    hold_reg, hold_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [KEY_LEN_W-1:0] key_length_reg;

    perm_req_t            perm_req;
    logic [BYTE_W-1:0]    perm_q;
    logic [BYTE_W-1:0]    key_q;
    logic                 key_wr;
    logic                 s_accept;
    logic                 out_free;
    logic [KEY_LEN_W-1:0] key_used;
    logic [KEY_LEN_W-1:0] key_last_w;
    logic [ADDR_W-1:0]    key_last;
    logic [BYTE_W-1:0]    ks_byte;
    logic [BYTE_W-1:0]    gen_byte;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // key length in use and the wrap point of the key index
    assign key_used   = (key_length_reg == '0) ? KEY_LEN_W'(1) :
                        (key_length_reg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_length_reg;
    assign key_last_w = key_used - KEY_LEN_W'(1);
    assign key_last   = key_last_w[ADDR_W-1:0];

    // keystream byte, with the two swapped entries forwarded
    assign ks_byte  = (t_reg == i_reg) ? sx_reg :
                      (t_reg == j_reg) ? si_reg : perm_q;
    assign gen_byte = data_reg ^ ks_byte;

    // key store
    assign key_wr = s_accept && (action_t'(s_tuser) == ACT_LOAD_KEY);

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_key_ram (
        .clk     (aclk),
        .wr_en   (key_wr),
        .wr_addr (s_tdata[7:0]),
        .wr_data (s_tdata[15:8]),
        .rd_addr (kk_reg),
        .rd_data (key_q)
    );

    // permutation table
    rc4_perm u_perm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (perm_req),
        .rd_data (perm_q)
    );

    // sequencer
    always_comb begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        kk_next          = kk_reg;
        si_next          = si_reg;
        sx_next          = sx_reg;
        t_next           = t_reg;
        data_next        = data_reg;
        hold_next        = hold_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        perm_req.clear   = 1'b0;
        perm_req.wr_en   = 1'b0;
        perm_req.wr_addr = i_reg;
        perm_req.wr_data = si_reg;
        perm_req.rd_addr = i_reg + ADDR_W'(1);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (action_t'(s_tuser))
                        ACT_DATA: begin
                            i_next     = i_reg + ADDR_W'(1);
                            data_next  = s_tdata[23:16];
                            state_next = ST_GEN_J;
                        end
                        ACT_SCHEDULE: begin
                            perm_req.clear = 1'b1;
                            j_next         = '0;
                            k_next         = '0;
                            kk_next        = '0;
                            state_next     = ST_KS_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // generator: j += S[i], fetch S[j]
            ST_GEN_J: begin
                si_next          = perm_q;
                j_next           = j_reg + perm_q;
                perm_req.rd_addr = j_reg + perm_q;
                state_next       = ST_GEN_SWAP_I;
            end

            // S[i] <= S[j], fetch the keystream entry
            ST_GEN_SWAP_I: begin
                sx_next          = perm_q;
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = i_reg;
                perm_req.wr_data = perm_q;
                t_next           = si_reg + perm_q;
                perm_req.rd_addr = si_reg + perm_q;
                state_next       = ST_GEN_SWAP_J;
            end

            // S[j] <= old S[i], form the result
            ST_GEN_SWAP_J: begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = j_reg;
                perm_req.wr_data = si_reg;
                if (out_free) begin
                    m_tdata_next  = gen_byte;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    hold_next  = gen_byte;
                    state_next = ST_GEN_OUT;
                end
            end

            // result waits for the output register
            ST_GEN_OUT: begin
                if (out_free) begin
                    m_tdata_next  = hold_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            // schedule step: fetch S[k]; key byte comes from kk
            ST_KS_READ: begin
                perm_req.rd_addr = k_reg;
                state_next       = ST_KS_J;
            end

            // j += S[k] + key, fetch S[j]
            ST_KS_J: begin
                si_next          = perm_q;
                j_next           = j_reg + perm_q + key_q;
                perm_req.rd_addr = j_reg + perm_q + key_q;
                state_next       = ST_KS_SWAP_K;
            end

            // S[k] <= S[j]
            ST_KS_SWAP_K: begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = k_reg;
                perm_req.wr_data = perm_q;
                state_next       = ST_KS_SWAP_J;
            end

            // S[j] <= old S[k], advance or finish
            ST_KS_SWAP_J: begin
                perm_req.wr_en   = 1'b1;
                perm_req.wr_addr = j_reg;
                perm_req.wr_data = si_reg;
                k_next           = k_reg + ADDR_W'(1);
                kk_next          = (kk_reg == key_last) ? '0 : kk_reg + ADDR_W'(1);
                if (k_reg == ADDR_W'(SBOX_DEPTH - 1)) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_KS_READ;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            m_tvalid_reg   <= 1'b0;
            key_length_reg <= KEY_LEN_RESET;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                key_length_reg <= cfg_data;
            end
        end
    end

    // working values
    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        kk_reg      <= kk_next;
        si_reg      <= si_next;
        sx_reg      <= sx_next;
        t_reg       <= t_next;
        data_reg    <= data_next;
        hold_reg    <= hold_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// File: rtl/rc4_ram.sv
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, registered read of the old contents
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/rc4_perm.sv
`default_nettype none

module rc4_perm (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire rc4_pkg::perm_req_t        req,
    output logic      [rc4_pkg::BYTE_W-1:0] rd_data
);

    import rc4_pkg::*;

    logic [SBOX_DEPTH-1:0] valid_reg;
    logic [SBOX_DEPTH-1:0] valid_next;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic [BYTE_W-1:0]     ram_q;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    // written marks; a clear returns the whole table to identity at once
    always_comb begin
        valid_next = valid_reg;
        if (req.clear) begin
            valid_next = '0;
        end else if (req.wr_en) begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // mark and address are registered alongside the ram read
    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[req.rd_addr];
        rd_addr_reg  <= req.rd_addr;
    end

    // an entry never written holds its own index
    assign rd_data = rd_valid_reg ? ram_q : rd_addr_reg;

endmodule

`default_nettype wire

// File: rtl/rc4_checker.sv
`default_nettype none
`include "rc4_stream_cipher_macros.svh"

module rc4_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [rc4_pkg::ACT_W-1:0]     s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rc4_pkg::BYTE_W-1:0]    m_tdata
);

    import rc4_pkg::*;

    // a stalled result beat holds
    `RC4_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // a data beat keeps the block busy while the swap runs
    `RC4_ASSERT(a_data_busy, s_tvalid && s_tready && s_tuser == ACT_DATA |=> !s_tready ##1 !s_tready ##1 !s_tready)

    // a key byte load leaves s_tready high in the following cycle
    `RC4_ASSERT(a_key_quick, s_tvalid && s_tready && s_tuser == ACT_LOAD_KEY |=> s_tready)

    // no result leaves right after reset
    `RC4_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid)

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);

`default_nettype wire

// File: verif/rc4_stream_cipher_test.sv
`timescale 1ns / 100ps

module rc4_stream_cipher_test;

    import rc4_pkg::*;

    // action code that the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int SCHEDULE_CYCLES = 1025;
    localparam int SETTLE_CYCLES   = SCHEDULE_CYCLES + 100;
    localparam int LONG_HOLD       = 2000;
    localparam int QUIET_LIMIT     = 30000;
    localparam int RANDOM_ITEMS    = 400;
    localparam int MAX_REPORTS     = 10;

    // predicts out_byte for every data beat and holds the bytes still owed
    class keystream_scoreboard;
        logic [BYTE_W-1:0]    perm [SBOX_DEPTH];
        logic [BYTE_W-1:0]    key_bytes [SBOX_DEPTH];
        logic [BYTE_W-1:0]    idx_i;
        logic [BYTE_W-1:0]    idx_j;
        logic [KEY_LEN_W-1:0] key_len;
        logic [BYTE_W-1:0]    expected_out_bytes [$];
        int                   mismatches;
        int                   reports;

        function new();
            for (int k = 0; k < SBOX_DEPTH; k++) begin
                perm[k]      = k[BYTE_W-1:0];
                key_bytes[k] = '0;
            end
            idx_i      = '0;
            idx_j      = '0;
            key_len    = KEY_LEN_RESET;
            mismatches = 0;
            reports    = 0;
        endfunction

        // zero acts as one, anything above the store size acts as full size
        static function int effective_len(logic [KEY_LEN_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > MAX_KEY_BYTES)
                return int'(MAX_KEY_BYTES);
            return int'(v);
        endfunction

        function void set_key_length(logic [KEY_LEN_W-1:0] v);
            key_len = v;
        endfunction

        function void swap_entries(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] t;
            t       = perm[a];
            perm[a] = perm[b];
            perm[b] = t;
        endfunction

        function void run_key_schedule();
            int                n;
            logic [BYTE_W-1:0] j;
            n = effective_len(key_len);
            j = '0;
            for (int k = 0; k < SBOX_DEPTH; k++)
                perm[k] = k[BYTE_W-1:0];
            for (int k = 0; k < SBOX_DEPTH; k++) begin
                j = j + perm[k] + key_bytes[k % n];
                swap_entries(k[BYTE_W-1:0], j);
            end
            idx_i = '0;
            idx_j = '0;
        endfunction

        function logic [BYTE_W-1:0] next_keystream();
            logic [BYTE_W-1:0] sum;
            idx_i = idx_i + 1'b1;
            idx_j = idx_j + perm[idx_i];
            swap_entries(idx_i, idx_j);
            sum = perm[idx_i] + perm[idx_j];
            return perm[sum];
        endfunction

        // accepted input beat: key_index [7:0], key_byte [15:8], data_byte [23:16]
        function void note_beat(logic [ACT_W-1:0] kind, logic [S_DATA_W-1:0] beat);
            case (kind)
                ACT_LOAD_KEY: key_bytes[beat[7:0]] = beat[15:8];
                ACT_SCHEDULE: run_key_schedule();
                ACT_DATA:     expected_out_bytes.push_back(beat[23:16] ^ next_keystream());
                default:      ;
            endcase
        endfunction

        function void check_out_byte(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            if (expected_out_bytes.size() == 0) begin
                mismatches++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected out_byte %02h with nothing pending", got);
                end
                return;
            end
            want = expected_out_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("out_byte mismatch: expected %02h actual %02h", want, got);
                end
            end
        endfunction

        function int error_count();
            return mismatches + expected_out_bytes.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [KEY_LEN_W-1:0] cfg_data;

    keystream_scoreboard board = new();

    // key store entries written since reset, so a schedule never reads a hole
    bit  key_loaded [SBOX_DEPTH];
    int  items_sent;
    int  burst_left;
    int  cur_key_len;
    bit  long_hold_req;
    int  hold_left;
    int  rx_mode;
    int  rx_run_left;
    int  quiet_cycles;

    rc4_stream_cipher u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // beat monitor: results before new inputs, then register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_out_byte(m_tdata);
            if (s_tvalid && s_tready)
                board.note_beat(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready)
                board.set_key_length(cfg_data);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise runs of varying stall density
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                rx_mode     = $urandom_range(0, 3);
                rx_run_left = $urandom_range(20, 200);
            end
            rx_run_left = rx_run_left - 1;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // offer one beat and hold it until taken, then maybe leave a gap
    task automatic send_beat(logic [ACT_W-1:0] kind, logic [7:0] key_idx,
                             logic [7:0] key_val, logic [7:0] data_val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {data_val, key_val, key_idx};
        do @(posedge aclk); while (!s_tready);
        if (kind == ACT_LOAD_KEY)
            key_loaded[key_idx] = 1'b1;
        if (kind != ACT_UNUSED)
            items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(1, 15);
            burst_left = $urandom_range(1, 40);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_offer();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender pauses until every owed byte is back and a schedule could have ended
    task automatic settle_block();
        stop_offer();
        while (board.expected_out_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_length(logic [KEY_LEN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_key_len = keystream_scoreboard::effective_len(v);
    endtask

    function automatic bit key_ready(int n);
        for (int k = 0; k < n; k++)
            if (!key_loaded[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // load missing key bytes plus a few fresh ones, schedule, then stream data
    task automatic run_key_session(int n, bit with_hold);
        int extra;
        int data_count;
        for (int k = 0; k < n; k++)
            if (!key_loaded[k])
                send_beat(ACT_LOAD_KEY, k[7:0], rand_byte(), rand_byte());
        extra = $urandom_range(0, (n < 8) ? n : 8);
        repeat (extra)
            send_beat(ACT_LOAD_KEY, 8'($urandom_range(0, n - 1)), rand_byte(), rand_byte());
        send_beat(ACT_SCHEDULE, rand_byte(), rand_byte(), rand_byte());
        if (with_hold)
            long_hold_req = 1'b1;
        data_count = with_hold ? 40 : $urandom_range(4, 30);
        repeat (data_count) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(ACT_UNUSED, rand_byte(), rand_byte(), rand_byte());
            send_beat(ACT_DATA, rand_byte(), rand_byte(), rand_byte());
        end
    endtask

    // stray beats: loads anywhere, ignored codes, data, and legal reschedules
    task automatic run_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0: send_beat(ACT_LOAD_KEY, 8'($urandom_range(0, 255)), rand_byte(), rand_byte());
                1: send_beat(ACT_UNUSED, rand_byte(), rand_byte(), rand_byte());
                2: send_beat(ACT_DATA, rand_byte(), rand_byte(), rand_byte());
                default: begin
                    if (key_ready(cur_key_len))
                        send_beat(ACT_SCHEDULE, rand_byte(), rand_byte(), rand_byte());
                    else
                        send_beat(ACT_DATA, rand_byte(), rand_byte(), rand_byte());
                end
            endcase
        end
    endtask

    initial begin
        int                   phase;
        logic [KEY_LEN_W-1:0] len_setting;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_LOAD_KEY;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        long_hold_req = 1'b0;
        hold_left     = 0;
        rx_mode       = 0;
        rx_run_left   = 0;
        quiet_cycles  = 0;
        items_sent    = 0;
        burst_left    = $urandom_range(1, 40);
        cur_key_len   = int'(KEY_LEN_RESET);
        for (int k = 0; k < SBOX_DEPTH; k++)
            key_loaded[k] = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero key length acts as one key byte
        write_key_length('0);
        // data before any schedule runs on the identity table
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_DATA, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ACT_LOAD_KEY, 8'h00, 8'hFF, 8'h00);
        send_beat(ACT_LOAD_KEY, 8'hFF, 8'h00, 8'hFF);
        send_beat(ACT_LOAD_KEY, 8'h80, 8'h5A, 8'hA5);
        send_beat(ACT_SCHEDULE, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'hFF);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'hA5);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'h3C);
        send_beat(ACT_UNUSED, 8'h00, 8'h00, 8'h00);
        // key changes do not touch the table until the next schedule
        send_beat(ACT_LOAD_KEY, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'h81);
        send_beat(ACT_SCHEDULE, 8'hFF, 8'hFF, 8'hFF);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'h7E);
        send_beat(ACT_DATA, 8'h00, 8'h00, 8'hFF);

        // random phases, each under its own key length; the long hold phase always runs
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS || phase < 2) begin
            case (phase)
                0:       len_setting = 9'h1FF;   // saturates to full store
                1:       len_setting = MAX_KEY_BYTES;
                2:       len_setting = 9'd1;
                default: len_setting = ($urandom_range(0, 5) == 0) ?
                                       KEY_LEN_W'($urandom_range(200, 300)) :
                                       KEY_LEN_W'($urandom_range(1, 20));
            endcase
            settle_block();
            write_key_length(len_setting);
            repeat ($urandom_range(2, 4)) begin
                if (phase == 1 || $urandom_range(0, 4) != 0)
                    run_key_session(cur_key_len, phase == 1);
                else
                    run_noise();
            end
            phase++;
        end

        settle_block();
        if (board.error_count() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
